// File: hdl/qfc_pkg.sv
// ----------------------------------------------------------------------------
// QR function-module classifier package
// Shared types, symbol-size limits and the alignment-centre table.
// ----------------------------------------------------------------------------
package qfc_pkg;

   localparam logic [7:0] SIZE_RESET = 8'd21;
   localparam logic [7:0] SIZE_MIN   = 8'd21;
   localparam logic [7:0] SIZE_MAX   = 8'd177;
   localparam logic [7:0] SIZE_BASE  = 8'd17;

   // Width of an alignment-position count; a version never has more than seven.
   localparam int CNT_W = 3;

   typedef struct packed {
      logic size_error;
      logic version_ge7;
   } size_info_type;

   typedef struct packed {
      logic reserved;
      logic size_error;
      logic outside;
   } result_type;

   // Alignment centre coordinates; row v-1 holds version v.
   localparam logic [7:0] ALIGN_TABLE [0:39][0:6] = '{
      '{8'd0,  8'd0,   8'd0,   8'd0,   8'd0,   8'd0,   8'd0  },
      '{8'd6,  8'd18,  8'd0,   8'd0,   8'd0,   8'd0,   8'd0  },
      '{8'd6,  8'd22,  8'd0,   8'd0,   8'd0,   8'd0,   8'd0  },
      '{8'd6,  8'd26,  8'd0,   8'd0,   8'd0,   8'd0,   8'd0  },
      '{8'd6,  8'd30,  8'd0,   8'd0,   8'd0,   8'd0,   8'd0  },
      '{8'd6,  8'd34,  8'd0,   8'd0,   8'd0,   8'd0,   8'd0  },
      '{8'd6,  8'd22,  8'd38,  8'd0,   8'd0,   8'd0,   8'd0  },
      '{8'd6,  8'd24,  8'd42,  8'd0,   8'd0,   8'd0,   8'd0  },
      '{8'd6,  8'd26,  8'd46,  8'd0,   8'd0,   8'd0,   8'd0  },
      '{8'd6,  8'd28,  8'd50,  8'd0,   8'd0,   8'd0,   8'd0  },
      '{8'd6,  8'd30,  8'd54,  8'd0,   8'd0,   8'd0,   8'd0  },
      '{8'd6,  8'd32,  8'd58,  8'd0,   8'd0,   8'd0,   8'd0  },
      '{8'd6,  8'd34,  8'd62,  8'd0,   8'd0,   8'd0,   8'd0  },
      '{8'd6,  8'd26,  8'd46,  8'd66,  8'd0,   8'd0,   8'd0  },
      '{8'd6,  8'd26,  8'd48,  8'd70,  8'd0,   8'd0,   8'd0  },
      '{8'd6,  8'd26,  8'd50,  8'd74,  8'd0,   8'd0,   8'd0  },
      '{8'd6,  8'd30,  8'd54,  8'd78,  8'd0,   8'd0,   8'd0  },
      '{8'd6,  8'd30,  8'd56,  8'd82,  8'd0,   8'd0,   8'd0  },
      '{8'd6,  8'd30,  8'd58,  8'd86,  8'd0,   8'd0,   8'd0  },
      '{8'd6,  8'd34,  8'd62,  8'd90,  8'd0,   8'd0,   8'd0  },
      '{8'd6,  8'd28,  8'd50,  8'd72,  8'd94,  8'd0,   8'd0  },
      '{8'd6,  8'd26,  8'd50,  8'd74,  8'd98,  8'd0,   8'd0  },
      '{8'd6,  8'd30,  8'd54,  8'd78,  8'd102, 8'd0,   8'd0  },
      '{8'd6,  8'd28,  8'd54,  8'd80,  8'd106, 8'd0,   8'd0  },
      '{8'd6,  8'd32,  8'd58,  8'd84,  8'd110, 8'd0,   8'd0  },
      '{8'd6,  8'd30,  8'd58,  8'd86,  8'd114, 8'd0,   8'd0  },
      '{8'd6,  8'd34,  8'd62,  8'd90,  8'd118, 8'd0,   8'd0  },
      '{8'd6,  8'd26,  8'd50,  8'd74,  8'd98,  8'd122, 8'd0  },
      '{8'd6,  8'd30,  8'd54,  8'd78,  8'd102, 8'd126, 8'd0  },
      '{8'd6,  8'd26,  8'd52,  8'd78,  8'd104, 8'd130, 8'd0  },
      '{8'd6,  8'd30,  8'd56,  8'd82,  8'd108, 8'd134, 8'd0  },
      '{8'd6,  8'd34,  8'd60,  8'd86,  8'd112, 8'd138, 8'd0  },
      '{8'd6,  8'd30,  8'd58,  8'd86,  8'd114, 8'd142, 8'd0  },
      '{8'd6,  8'd34,  8'd62,  8'd90,  8'd118, 8'd146, 8'd0  },
      '{8'd6,  8'd30,  8'd54,  8'd78,  8'd102, 8'd126, 8'd150},
      '{8'd6,  8'd24,  8'd50,  8'd76,  8'd106, 8'd128, 8'd154},
      '{8'd6,  8'd28,  8'd54,  8'd80,  8'd106, 8'd132, 8'd158},
      '{8'd6,  8'd32,  8'd58,  8'd84,  8'd110, 8'd136, 8'd162},
      '{8'd6,  8'd26,  8'd54,  8'd82,  8'd110, 8'd138, 8'd166},
      '{8'd6,  8'd30,  8'd58,  8'd86,  8'd114, 8'd142, 8'd170}
   };

   // Number of alignment positions for a version: none for version 1,
   // otherwise two plus one for every seven versions.
   function automatic logic [CNT_W-1:0] align_count(input int ver);
      logic [CNT_W-1:0] cnt;
      if (ver <= 1) begin
         cnt = CNT_W'(0);
      end else if (ver < 7) begin
         cnt = CNT_W'(2);
      end else if (ver < 14) begin
         cnt = CNT_W'(3);
      end else if (ver < 21) begin
         cnt = CNT_W'(4);
      end else if (ver < 28) begin
         cnt = CNT_W'(5);
      end else if (ver < 35) begin
         cnt = CNT_W'(6);
      end else begin
         cnt = CNT_W'(7);
      end
      return cnt;
   endfunction

endpackage

// File: hdl/qfc_align_rom.sv
// ----------------------------------------------------------------------------
// Alignment position memory
// Synchronous memory with one row per version: the alignment centres and
// their count. Loaded from the constant table by a sweep after reset.
// ----------------------------------------------------------------------------
module qfc_align_rom #(
   parameter int MAX_VERSION         = 40,
   parameter int MAX_ALIGN_POSITIONS = 7,
   parameter int ADDR_W              = 6
) (
   input  logic                                   clock,
   input  logic                                   reset,
   input  logic                                   rd_en,
   input  logic [ADDR_W-1:0]                      rd_addr,
   output logic [MAX_ALIGN_POSITIONS-1:0][7:0]    rd_pos,
   output logic [qfc_pkg::CNT_W-1:0]              rd_count,
   output logic                                   init_done
);
   import qfc_pkg::*;

   localparam int POS_W = MAX_ALIGN_POSITIONS * 8;
   localparam int ROW_W = POS_W + CNT_W;

   logic [ROW_W-1:0]  mem [MAX_VERSION];
   logic [ROW_W-1:0]  rd_data_ff;
   logic [ROW_W-1:0]  wr_row;
   logic [ADDR_W-1:0] init_ptr_ff;
   logic [ADDR_W-1:0] init_ptr_in;
   logic              init_done_ff;
   logic              init_done_in;
   logic [CNT_W-1:0]  full_count;

   // Row contents for the entry currently being loaded.
   always_comb begin
      full_count = align_count(int'(init_ptr_ff) + 1);
      for (int i = 0; i < MAX_ALIGN_POSITIONS; i++) begin
         wr_row[i*8 +: 8] = ALIGN_TABLE[init_ptr_ff][i];
      end
      if (full_count > CNT_W'(MAX_ALIGN_POSITIONS)) begin
         wr_row[POS_W +: CNT_W] = CNT_W'(MAX_ALIGN_POSITIONS);
      end else begin
         wr_row[POS_W +: CNT_W] = full_count;
      end
   end

   always_comb begin
      init_ptr_in  = init_ptr_ff;
      init_done_in = init_done_ff;
      if (!init_done_ff) begin
         if (init_ptr_ff == ADDR_W'(MAX_VERSION - 1)) begin
            init_done_in = 1'b1;
         end else begin
            init_ptr_in = init_ptr_ff + ADDR_W'(1);
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         init_ptr_ff  <= '0;
         init_done_ff <= 1'b0;
      end else begin
         init_ptr_ff  <= init_ptr_in;
         init_done_ff <= init_done_in;
      end
   end

   always_ff @(posedge clock) begin
      if (!init_done_ff) begin
         mem[init_ptr_ff] <= wr_row;
      end
   end

   always_ff @(posedge clock) begin
      if (rd_en) begin
         rd_data_ff <= mem[rd_addr];
      end
   end

   always_comb begin
      for (int i = 0; i < MAX_ALIGN_POSITIONS; i++) begin
         rd_pos[i] = rd_data_ff[i*8 +: 8];
      end
   end

   assign rd_count  = rd_data_ff[POS_W +: CNT_W];
   assign init_done = init_done_ff;

endmodule

// File: hdl/qfc_region_check.sv
// ----------------------------------------------------------------------------
// Function-region compare stage
// Tests one coordinate against the finder corners, timing lines, version
// blocks and the alignment patterns read from the position memory.
// ----------------------------------------------------------------------------
module qfc_region_check #(
   parameter int MAX_ALIGN_POSITIONS = 7
) (
   input  logic [7:0]                             column,
   input  logic [7:0]                             row,
   input  logic [7:0]                             size,
   input  qfc_pkg::size_info_type                 info,
   input  logic [MAX_ALIGN_POSITIONS-1:0][7:0]    pos,
   input  logic [qfc_pkg::CNT_W-1:0]              count,
   output qfc_pkg::result_type                    result
);
   import qfc_pkg::*;

   logic [8:0] x9;
   logic [8:0] y9;
   logic [8:0] s9;
   logic [8:0] sm7;
   logic [8:0] sm8;
   logic [8:0] sm11;
   logic       outside;
   logic       corner_hit;
   logic       timing_hit;
   logic       version_hit;
   logic       align_hit;
   logic [MAX_ALIGN_POSITIONS-1:0] near_x;
   logic [MAX_ALIGN_POSITIONS-1:0] near_y;
   logic [MAX_ALIGN_POSITIONS-1:0] is6;
   logic [MAX_ALIGN_POSITIONS-1:0] is_far;
   logic [MAX_ALIGN_POSITIONS-1:0] in_list;

   // The size-relative bounds only matter for a legal size, which is at least
   // 21, so the subtractions never wrap where the result is used.
   assign x9   = {1'b0, column};
   assign y9   = {1'b0, row};
   assign s9   = {1'b0, size};
   assign sm7  = s9 - 9'd7;
   assign sm8  = s9 - 9'd8;
   assign sm11 = s9 - 9'd11;

   assign outside = (x9 >= s9) || (y9 >= s9);

   assign corner_hit = ((x9 < 9'd9) && (y9 < 9'd9))
                    || ((x9 < 9'd9) && (y9 >= sm8))
                    || ((x9 >= sm8) && (y9 < 9'd9));

   assign timing_hit = (x9 == 9'd6) || (y9 == 9'd6);

   assign version_hit = info.version_ge7
                     && (((x9 < 9'd6) && (y9 >= sm11) && (y9 < sm8))
                      || ((y9 < 9'd6) && (x9 >= sm11) && (x9 < sm8)));

   always_comb begin
      for (int i = 0; i < MAX_ALIGN_POSITIONS; i++) begin
         near_x[i]  = (x9 + 9'd2 >= {1'b0, pos[i]}) && (x9 <= {1'b0, pos[i]} + 9'd2);
         near_y[i]  = (y9 + 9'd2 >= {1'b0, pos[i]}) && (y9 <= {1'b0, pos[i]} + 9'd2);
         is6[i]     = (pos[i] == 8'd6);
         is_far[i]  = ({1'b0, pos[i]} == sm7);
         in_list[i] = (CNT_W'(i) < count);
      end
   end

   // Every pair of listed centres forms a pattern, except the three that
   // would sit on top of a finder.
   always_comb begin
      align_hit = 1'b0;
      for (int i = 0; i < MAX_ALIGN_POSITIONS; i++) begin
         for (int j = 0; j < MAX_ALIGN_POSITIONS; j++) begin
            if (in_list[i] && in_list[j] && near_x[i] && near_y[j]
                && !(is6[i] && is6[j]) && !(is6[i] && is_far[j])
                && !(is_far[i] && is6[j])) begin
               align_hit = 1'b1;
            end
         end
      end
   end

   always_comb begin
      result.size_error = info.size_error;
      result.outside    = outside;
      result.reserved   = !info.size_error && !outside
                        && (corner_hit || timing_hit || version_hit || align_hit);
   end

endmodule

// File: hdl/qr_function_module_classifier.sv
// An accepted request passes through the request register and then the response register.
// Throughput: one coordinate per cycle; the position memory is read alongside
// the request register whenever the pipeline moves, then the compare stage fills
// the response register. A stalled response holds the whole pipeline.
// Reset: the size register returns to 21 and the position memory is loaded
// one row per version, during which requests are stalled.
// ----------------------------------------------------------------------------
// QR function-module classifier
// Reports whether a module coordinate belongs to a function pattern of a QR
// symbol whose side length is held in a configuration register.
// ----------------------------------------------------------------------------
module qr_function_module_classifier #(
   parameter int MAX_VERSION         = 40,
   parameter int MAX_ALIGN_POSITIONS = 7
) (
   input  logic       clock,
   input  logic       reset,
   input  logic       csr_wr_en,
   input  logic [7:0] csr_wr_data,
   input  logic       req_valid,
   output logic       req_stall,
   input  logic [7:0] req_column,
   input  logic [7:0] req_row,
   output logic       rsp_valid,
   input  logic       rsp_stall,
   output logic       rsp_reserved,
   output logic       rsp_size_error,
   output logic       rsp_outside
);
   import qfc_pkg::*;

   localparam int ADDR_W = (MAX_VERSION > 1) ? $clog2(MAX_VERSION) : 1;

   logic [7:0]  size_ff;
   logic [7:0]  size_in;
   logic [7:0]  size_sub;
   logic [5:0]  version;
   logic        size_legal;
   logic [ADDR_W-1:0] rom_addr;
   size_info_type size_info;

   logic        pipe_en;
   logic        accept;
   logic        init_done;
   logic        s1_valid_ff;
   logic        s1_valid_in;
   logic [7:0]  s1_column_ff;
   logic [7:0]  s1_row_ff;
   logic        rsp_valid_ff;
   logic        rsp_valid_in;
   result_type  rsp_result_ff;
   result_type  check_result;

   logic [MAX_ALIGN_POSITIONS-1:0][7:0] rom_pos;
   logic [CNT_W-1:0]                    rom_count;

   // Size register and version decode.
   assign size_in  = csr_wr_en ? csr_wr_data : size_ff;
   assign size_sub = size_ff - SIZE_BASE;
   assign version  = size_sub[7:2];

   assign size_legal = (size_ff >= SIZE_MIN) && (size_ff <= SIZE_MAX)
                    && (size_ff[1:0] == 2'b01) && (int'(version) <= MAX_VERSION);

   assign size_info.size_error  = !size_legal;
   assign size_info.version_ge7 = (version >= 6'd7);

   assign rom_addr = size_legal ? ADDR_W'(version - 6'd1) : '0;

   always_ff @(posedge clock) begin
      if (reset) begin
         size_ff <= SIZE_RESET;
      end else begin
         size_ff <= size_in;
      end
   end

   // The pipeline moves as one unless a response is waiting and stalled.
   assign pipe_en   = !(rsp_valid_ff && rsp_stall);
   assign req_stall = !pipe_en || !init_done;
   assign accept    = req_valid && !req_stall;

   assign s1_valid_in  = pipe_en ? accept : s1_valid_ff;
   assign rsp_valid_in = pipe_en ? s1_valid_ff : rsp_valid_ff;

   always_ff @(posedge clock) begin
      if (reset) begin
         s1_valid_ff  <= 1'b0;
         rsp_valid_ff <= 1'b0;
      end else begin
         s1_valid_ff  <= s1_valid_in;
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      if (pipe_en) begin
         s1_column_ff  <= req_column;
         s1_row_ff     <= req_row;
         rsp_result_ff <= check_result;
      end
   end

   qfc_align_rom #(
      .MAX_VERSION         (MAX_VERSION),
      .MAX_ALIGN_POSITIONS (MAX_ALIGN_POSITIONS),
      .ADDR_W              (ADDR_W)
   ) u_align_rom (
      .clock     (clock),
      .reset     (reset),
      .rd_en     (pipe_en),
      .rd_addr   (rom_addr),
      .rd_pos    (rom_pos),
      .rd_count  (rom_count),
      .init_done (init_done)
   );

   qfc_region_check #(
      .MAX_ALIGN_POSITIONS (MAX_ALIGN_POSITIONS)
   ) u_region_check (
      .column (s1_column_ff),
      .row    (s1_row_ff),
      .size   (size_ff),
      .info   (size_info),
      .pos    (rom_pos),
      .count  (rom_count),
      .result (check_result)
   );

   assign rsp_valid      = rsp_valid_ff;
   assign rsp_reserved   = rsp_result_ff.reserved;
   assign rsp_size_error = rsp_result_ff.size_error;
   assign rsp_outside    = rsp_result_ff.outside;

endmodule

// File: hdl/qfc_checker.sv
// ----------------------------------------------------------------------------
// QR function-module classifier port checker
// Watches the top-level ports for ordering, latency and result consistency.
// ----------------------------------------------------------------------------
module qfc_checker (
   input logic clock,
   input logic reset,
   input logic req_valid,
   input logic req_stall,
   input logic rsp_valid,
   input logic rsp_stall,
   input logic rsp_reserved,
   input logic rsp_size_error,
   input logic rsp_outside
);

   // No response may be presented in the cycle after reset.
   assert property (@(posedge clock) !reset && $past(reset) |-> !rsp_valid)
      else $error("response valid straight after reset");

   // A stalled response transaction stays put.
   assert property (@(posedge clock) disable iff (reset)
      rsp_valid && rsp_stall |=> rsp_valid && $stable(rsp_reserved)
         && $stable(rsp_size_error) && $stable(rsp_outside))
      else $error("stalled response changed");

   // An accepted request reaches the output unless a stalled response holds the pipeline.
   assert property (@(posedge clock) disable iff (reset)
      (req_valid && !req_stall) ##1 !(rsp_valid && rsp_stall) |=> rsp_valid)
      else $error("response missing after accepted request");

   // A module outside the symbol or in an illegal symbol is never reserved.
   assert property (@(posedge clock) disable iff (reset)
      rsp_valid && (rsp_outside || rsp_size_error) |-> !rsp_reserved)
      else $error("reserved flagged with error or outside");

endmodule

bind qr_function_module_classifier qfc_checker u_qfc_checker (
   .clock          (clock),
   .reset          (reset),
   .req_valid      (req_valid),
   .req_stall      (req_stall),
   .rsp_valid      (rsp_valid),
   .rsp_stall      (rsp_stall),
   .rsp_reserved   (rsp_reserved),
   .rsp_size_error (rsp_size_error),
   .rsp_outside    (rsp_outside)
);

// File: test/qr_function_module_classifier_tb.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// QR function-module classifier testbench
// Drives module coordinates in random bursts against a range of symbol
// sizes, legal and illegal. Every response is checked against a local
// classifier of finder, timing, version and alignment regions.
// ----------------------------------------------------------------------------
module qr_function_module_classifier_tb;

   localparam int SIZE_LO      = 21;
   localparam int SIZE_HI      = 177;
   localparam int SIZE_AT_RST  = 21;
   localparam int RANDOM_BATCH = 30;

   // Alignment centres; row v-1 holds version v.
   localparam logic [7:0] CENTRES [40][7] = '{
      '{0,  0,   0,   0,   0,   0,   0  },
      '{6,  18,  0,   0,   0,   0,   0  },
      '{6,  22,  0,   0,   0,   0,   0  },
      '{6,  26,  0,   0,   0,   0,   0  },
      '{6,  30,  0,   0,   0,   0,   0  },
      '{6,  34,  0,   0,   0,   0,   0  },
      '{6,  22,  38,  0,   0,   0,   0  },
      '{6,  24,  42,  0,   0,   0,   0  },
      '{6,  26,  46,  0,   0,   0,   0  },
      '{6,  28,  50,  0,   0,   0,   0  },
      '{6,  30,  54,  0,   0,   0,   0  },
      '{6,  32,  58,  0,   0,   0,   0  },
      '{6,  34,  62,  0,   0,   0,   0  },
      '{6,  26,  46,  66,  0,   0,   0  },
      '{6,  26,  48,  70,  0,   0,   0  },
      '{6,  26,  50,  74,  0,   0,   0  },
      '{6,  30,  54,  78,  0,   0,   0  },
      '{6,  30,  56,  82,  0,   0,   0  },
      '{6,  30,  58,  86,  0,   0,   0  },
      '{6,  34,  62,  90,  0,   0,   0  },
      '{6,  28,  50,  72,  94,  0,   0  },
      '{6,  26,  50,  74,  98,  0,   0  },
      '{6,  30,  54,  78,  102, 0,   0  },
      '{6,  28,  54,  80,  106, 0,   0  },
      '{6,  32,  58,  84,  110, 0,   0  },
      '{6,  30,  58,  86,  114, 0,   0  },
      '{6,  34,  62,  90,  118, 0,   0  },
      '{6,  26,  50,  74,  98,  122, 0  },
      '{6,  30,  54,  78,  102, 126, 0  },
      '{6,  26,  52,  78,  104, 130, 0  },
      '{6,  30,  56,  82,  108, 134, 0  },
      '{6,  34,  60,  86,  112, 138, 0  },
      '{6,  30,  58,  86,  114, 142, 0  },
      '{6,  34,  62,  90,  118, 146, 0  },
      '{6,  30,  54,  78,  102, 126, 150},
      '{6,  24,  50,  76,  106, 128, 154},
      '{6,  28,  54,  80,  106, 132, 158},
      '{6,  32,  58,  84,  110, 136, 162},
      '{6,  26,  54,  82,  110, 138, 166},
      '{6,  30,  58,  86,  114, 142, 170}
   };

   typedef struct packed {
      logic [7:0] column;
      logic [7:0] row;
   } coord_type;

   typedef struct packed {
      logic reserved;
      logic size_error;
      logic outside;
   } class_type;

   typedef struct packed {
      coord_type coord;
      class_type cls;
   } expected_type;

   typedef enum int {STALL_NONE, STALL_LIGHT, STALL_HEAVY, STALL_TOGGLE} stall_mode_type;

   logic       clock = 1'b0;
   logic       reset = 1'b1;
   logic       csr_wr_en = 1'b0;
   logic [7:0] csr_wr_data = 8'd0;
   logic       req_valid = 1'b0;
   logic       req_stall;
   logic [7:0] req_column = 8'd0;
   logic [7:0] req_row = 8'd0;
   logic       rsp_valid;
   logic       rsp_stall = 1'b0;
   logic       rsp_reserved;
   logic       rsp_size_error;
   logic       rsp_outside;

   coord_type      pending_coords [$];
   expected_type   expected_results [$];
   logic [7:0]     cfg_size = 8'(SIZE_AT_RST);
   bit             req_fire = 1'b0;
   int             errors = 0;
   int             burst_left = 0;
   int             gap_left = 0;
   int             stall_left = 0;
   stall_mode_type stall_mode = STALL_NONE;
   coord_type      drv_coord;
   expected_type   got;

   qr_function_module_classifier u_dut (
      .clock          (clock),
      .reset          (reset),
      .csr_wr_en      (csr_wr_en),
      .csr_wr_data    (csr_wr_data),
      .req_valid      (req_valid),
      .req_stall      (req_stall),
      .req_column     (req_column),
      .req_row        (req_row),
      .rsp_valid      (rsp_valid),
      .rsp_stall      (rsp_stall),
      .rsp_reserved   (rsp_reserved),
      .rsp_size_error (rsp_size_error),
      .rsp_outside    (rsp_outside)
   );

   always begin
      #5 clock = 1'b1;
      #5 clock = 1'b0;
   end

   function automatic bit size_is_legal(int s);
      return s >= SIZE_LO && s <= SIZE_HI && (s % 4) == 1;
   endfunction

   function automatic int centre_count(int ver);
      int n;
      n = (ver == 1) ? 0 : ver / 7 + 2;
      if (n > 7) n = 7;
      return n;
   endfunction

   function automatic class_type classify_module(logic [7:0] column, logic [7:0] row,
                                                 logic [7:0] size);
      class_type r;
      int x, y, s, ver, n, i, j, px, py;
      x = int'(column);
      y = int'(row);
      s = int'(size);
      r.size_error = !size_is_legal(s);
      r.outside    = (x >= s || y >= s);
      r.reserved   = 1'b0;
      if (!r.size_error && !r.outside) begin
         ver = (s - 17) / 4;
         if ((x < 9 && y < 9) || (x < 9 && y >= s - 8) || (x >= s - 8 && y < 9) ||
             x == 6 || y == 6) begin
            r.reserved = 1'b1;
         end else if (ver >= 7 && ((x < 6 && y >= s - 11 && y < s - 8) ||
                                   (y < 6 && x >= s - 11 && x < s - 8))) begin
            r.reserved = 1'b1;
         end else begin
            n = centre_count(ver);
            for (i = 0; i < n; i++) begin
               for (j = 0; j < n; j++) begin
                  px = int'(CENTRES[ver-1][i]);
                  py = int'(CENTRES[ver-1][j]);
                  // The three centres under the finder corners carry no pattern.
                  if (!((px == 6 && py == 6) || (px == 6 && py == s - 7) ||
                        (px == s - 7 && py == 6)) &&
                      x >= px - 2 && x <= px + 2 && y >= py - 2 && y <= py + 2) begin
                     r.reserved = 1'b1;
                  end
               end
            end
         end
      end
      return r;
   endfunction

   // Draws a coordinate biased towards the interesting parts of the symbol.
   function automatic coord_type random_coord(int s);
      coord_type c;
      int pick, ver, n;
      pick = $urandom_range(0, 99);
      if (pick < 15 || !size_is_legal(s)) begin
         c.column = 8'($urandom);
         c.row    = 8'($urandom);
      end else if (pick < 45) begin
         // Near the edges, where the corners and version blocks lie.
         c.column = ($urandom_range(0, 1) == 0) ? 8'($urandom_range(0, 12))
                                                : 8'(s - 13 + $urandom_range(0, 14));
         c.row    = ($urandom_range(0, 1) == 0) ? 8'($urandom_range(0, 12))
                                                : 8'(s - 13 + $urandom_range(0, 14));
      end else if (pick < 70 && s > SIZE_LO) begin
         ver = (s - 17) / 4;
         n = centre_count(ver);
         c.column = 8'(CENTRES[ver-1][$urandom_range(0, n - 1)]
                       + $urandom_range(0, 6) - 3);
         c.row    = 8'(CENTRES[ver-1][$urandom_range(0, n - 1)]
                       + $urandom_range(0, 6) - 3);
      end else begin
         c.column = 8'($urandom_range(0, s - 1));
         c.row    = 8'($urandom_range(0, s - 1));
      end
      return c;
   endfunction

   task automatic wait_idle();
      do @(posedge clock);
      while (pending_coords.size() != 0 || req_valid || expected_results.size() != 0);
   endtask

   task automatic program_size(logic [7:0] value);
      wait_idle();
      @(negedge clock);
      csr_wr_en   <= 1'b1;
      csr_wr_data <= value;
      @(negedge clock);
      csr_wr_en   <= 1'b0;
   endtask

   task automatic queue_coord(int column, int row);
      coord_type c;
      c.column = 8'(column);
      c.row    = 8'(row);
      pending_coords.push_back(c);
   endtask

   task automatic queue_random(int count, int s);
      for (int k = 0; k < count; k++) pending_coords.push_back(random_coord(s));
   endtask

   task automatic check_field(string name, coord_type c, logic exp_bit, logic act_bit);
      if (exp_bit !== act_bit) begin
         $display("%0t: %s mismatch at column %0d row %0d: expected %0b, actual %0b",
                  $time, name, c.column, c.row, exp_bit, act_bit);
         errors++;
      end
   endtask

   // Request driver: bursts of transactions separated by random gaps.
   always @(negedge clock) begin
      if (reset) begin
         req_valid <= 1'b0;
      end else if (!req_valid || req_fire) begin
         if (gap_left > 0 || pending_coords.size() == 0) begin
            if (gap_left > 0) gap_left--;
            req_valid <= 1'b0;
         end else begin
            drv_coord = pending_coords.pop_front();
            req_valid  <= 1'b1;
            req_column <= drv_coord.column;
            req_row    <= drv_coord.row;
            if (burst_left > 0) begin
               burst_left--;
            end else begin
               burst_left = $urandom_range(1, 24);
               gap_left   = ($urandom_range(0, 2) == 0) ? 0 : $urandom_range(1, 6);
            end
         end
      end
   end

   // Response stall pattern: stretches of no, light, heavy or alternating stall.
   always @(negedge clock) begin
      if (reset) begin
         rsp_stall <= 1'b0;
      end else begin
         if (stall_left == 0) begin
            stall_mode = stall_mode_type'($urandom_range(0, 3));
            stall_left = $urandom_range(8, 40);
         end else begin
            stall_left--;
         end
         case (stall_mode)
            STALL_NONE: begin
               rsp_stall <= 1'b0;
            end
            STALL_LIGHT: begin
               rsp_stall <= ($urandom_range(0, 3) == 0);
            end
            STALL_HEAVY: begin
               rsp_stall <= ($urandom_range(0, 3) != 0);
            end
            default: begin
               rsp_stall <= ~rsp_stall;
            end
         endcase
      end
   end

   // Monitor: records accepted requests with their expected class and checks
   // each accepted response against the oldest one.
   always @(posedge clock) begin
      if (reset) begin
         cfg_size = 8'(SIZE_AT_RST);
         req_fire = 1'b0;
      end else begin
         if (csr_wr_en) cfg_size = csr_wr_data;
         req_fire = req_valid && !req_stall;
         if (req_fire) begin
            got.coord.column = req_column;
            got.coord.row    = req_row;
            got.cls = classify_module(req_column, req_row, cfg_size);
            expected_results.push_back(got);
         end
         if (rsp_valid && !rsp_stall) begin
            if (expected_results.size() == 0) begin
               $display("%0t: unexpected response transaction: expected none, actual %0b%0b%0b",
                        $time, rsp_reserved, rsp_size_error, rsp_outside);
               errors++;
            end else begin
               got = expected_results.pop_front();
               check_field("reserved", got.coord, got.cls.reserved, rsp_reserved);
               check_field("size_error", got.coord, got.cls.size_error, rsp_size_error);
               check_field("outside", got.coord, got.cls.outside, rsp_outside);
            end
         end
      end
   end

   initial begin
      logic [7:0] size;
      repeat (7) @(posedge clock);
      @(negedge clock);
      reset <= 1'b0;

      // Reset size, version 1: corners, their borders and far outside.
      queue_coord(0, 0);
      queue_coord(8, 8);
      queue_coord(9, 9);
      queue_coord(8, 13);
      queue_coord(9, 13);
      queue_coord(13, 9);
      queue_coord(20, 20);
      queue_coord(255, 255);
      queue_random(RANDOM_BATCH, SIZE_AT_RST);

      // Version 2: edge of the single alignment pattern.
      program_size(8'd25);
      queue_coord(16, 16);
      queue_coord(15, 16);
      queue_random(RANDOM_BATCH, 25);

      // Version 6: the version-block area is still data.
      program_size(8'd41);
      queue_coord(0, 30);
      queue_coord(30, 0);
      queue_random(RANDOM_BATCH, 41);

      // Version 7: version blocks appear.
      program_size(8'd45);
      queue_coord(5, 34);
      queue_coord(0, 33);
      queue_coord(34, 5);
      queue_coord(33, 0);
      queue_coord(22, 20);
      queue_random(RANDOM_BATCH, 45);

      // Largest legal symbol.
      program_size(8'd177);
      queue_coord(176, 176);
      queue_coord(170, 170);
      queue_coord(177, 0);
      queue_random(RANDOM_BATCH, 177);

      // Illegal sizes: zero, all ones, wrong residue, too large.
      program_size(8'd0);
      queue_coord(0, 0);
      queue_random(RANDOM_BATCH, 0);
      program_size(8'd255);
      queue_coord(254, 254);
      queue_random(RANDOM_BATCH, 255);
      program_size(8'd23);
      queue_coord(10, 10);
      queue_random(RANDOM_BATCH, 23);
      program_size(8'd181);
      queue_coord(10, 10);
      queue_random(RANDOM_BATCH, 181);

      for (int p = 0; p < 4; p++) begin
         if ($urandom_range(0, 3) == 0) size = 8'($urandom);
         else size = 8'(SIZE_LO + 4 * $urandom_range(0, 39));
         program_size(size);
         queue_random(RANDOM_BATCH, int'(size));
      end

      wait_idle();
      repeat (8) @(posedge clock);
      if (errors == 0) begin
         $display("PASS");
      end else begin
         $display("FAIL");
      end
      $finish;
   end

   initial begin
      #2000000;
      $display("FAIL");
      $finish;
   end

endmodule

// File: sim.f
hdl/qfc_pkg.sv
hdl/qfc_align_rom.sv
hdl/qfc_region_check.sv
hdl/qr_function_module_classifier.sv
hdl/qfc_checker.sv
test/qr_function_module_classifier_tb.sv
